FILE: hw/rtl/spp_pkg.sv
// Package for the spectrum top-peak picker: widths, list entry and cell control types.
// Used by spp_cell, spp_ratio_div and spectrum_top_peak_picker_core.
package spp_pkg;

	localparam int POWER_BITS = 24;
	localparam int AMP_W      = 24;
	localparam int BIN_W      = 16;
	localparam int CNT_W      = BIN_W + 1;
	localparam int MAX_BINS   = 65536;
	localparam int TOP_PEAKS  = 20;
	localparam int SUM_W      = POWER_BITS + BIN_W;
	localparam int PN_W       = POWER_BITS + CNT_W;
	localparam int FREQ_W     = 48;
	localparam int FRAC_W     = 24;
	localparam int STEP_W     = 5;
	localparam int RATIO_W    = 24;
	localparam int RATIO_FRAC = 16;
	localparam int RATIO_INT  = RATIO_W - RATIO_FRAC;

	// Configuration register indexes
	localparam logic REG_MIN_FREQ = 1'b0;
	localparam logic REG_STEP_EXP = 1'b1;

	// One slot of the sorted peak list
	typedef struct packed {
		logic                  valid;
		logic [POWER_BITS-1:0] power;
		logic [AMP_W-1:0]      amp;
		logic [BIN_W-1:0]      idx;
	} peak_entry_t;

	// Commands broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic pop;
		logic clear;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/spp_cell.sv
// One cell of the sorted peak chain: holds one entry, compares against the newcomer
// and trades entries with its neighbors. Depends on spp_pkg.
module spp_cell
	import spp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cell_ctl_t   ctl,
	input  peak_entry_t new_ent,
	input  peak_entry_t up_ent,
	input  logic        up_gt,
	input  peak_entry_t down_ent,
	output peak_entry_t ent,
	output logic        gt
);

	logic                  valid_q;
	logic [POWER_BITS-1:0] power_q;
	logic [AMP_W-1:0]      amp_q;
	logic [BIN_W-1:0]      idx_q;

	// Newcomer ranks above this slot (empty slots always lose; ties stay put)
	assign gt = !valid_q || (power_q < new_ent.power);

	assign ent = '{valid: valid_q, power: power_q, amp: amp_q, idx: idx_q};

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			if (gt && !up_gt) begin
				valid_q <= 1'b1;
			end else if (gt) begin
				valid_q <= up_ent.valid;
			end
		end else if (ctl.pop) begin
			valid_q <= down_ent.valid;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (gt && !up_gt) begin
				power_q <= new_ent.power;
				amp_q   <= new_ent.amp;
				idx_q   <= new_ent.idx;
			end else if (gt) begin
				power_q <= up_ent.power;
				amp_q   <= up_ent.amp;
				idx_q   <= up_ent.idx;
			end
		end else if (ctl.pop) begin
			power_q <= down_ent.power;
			amp_q   <= down_ent.amp;
			idx_q   <= down_ent.idx;
		end
	end

endmodule

FILE: hw/rtl/spp_ratio_div.sv
// Ratio unit: floor(pn * 2^16 / sum), saturating to 24 bits, by restoring
// division one quotient bit per cycle. Depends on spp_pkg.
module spp_ratio_div
	import spp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PN_W-1:0]    pn,
	input  logic [SUM_W-1:0]   sum,
	output logic               done,
	output logic [RATIO_W-1:0] ratio
);

	localparam int SAT_W  = SUM_W + RATIO_INT;
	localparam int STEP_CW = $clog2(RATIO_W);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_CW-1:0]   step_q;
	logic [SUM_W-1:0]     rem_q;
	logic [SUM_W-1:0]     den_q;
	logic [RATIO_INT-1:0] nb_q;
	logic [RATIO_W-1:0]   quo_q;

	logic                 sat;
	logic [SUM_W:0]       trial;
	logic                 fits;

	// Quotient of 256 or more (or a zero sum) saturates
	assign sat   = {{(SAT_W-PN_W){1'b0}}, pn} >= {sum, {RATIO_INT{1'b0}}};
	assign trial = {rem_q, nb_q[RATIO_INT-1]};
	assign fits  = trial >= {1'b0, den_q};

	assign done  = done_q;
	assign ratio = quo_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				done_q <= sat;
				step_q <= STEP_CW'(RATIO_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= sum;
			rem_q <= SUM_W'(pn[PN_W-1:RATIO_INT]);
			nb_q  <= pn[RATIO_INT-1:0];
			quo_q <= sat ? {RATIO_W{1'b1}} : '0;
		end else if (busy_q) begin
			nb_q <= {nb_q[RATIO_INT-2:0], 1'b0};
			if (fits) begin
				rem_q <= SUM_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[RATIO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[SUM_W-1:0];
				quo_q <= {quo_q[RATIO_W-2:0], 1'b0};
			end
		end
	end

endmodule

FILE: hw/rtl/spectrum_top_peak_picker_core.sv
// Spectrum top-peak picker top level: bin intake, chain of sorted peak cells,
// result sequencer. Depends on spp_pkg, spp_cell and spp_ratio_div.
//
//   channel   | direction | transaction carries
//   s_axis    | in        | one periodogram bin, tlast on the final bin
//   m_axis    | out       | one reported peak (or a single "none" result), tlast on the last
//   cfg       | in        | register write, no handshake
//
// Bins: one per cycle; each bin updates the whole chain in the cycle it is taken.
// After the final bin the intake stalls: the head power is multiplied by the bin count
// and the list head checked, then per reported peak the head is popped, its ratio runs
// through the bit-serial divider (which does not iterate when the ratio saturates), the
// next head is multiplied and checked, and the result waits on m_axis_tready. The "none"
// result follows the first check. The chain clears when the last result is taken.
// Reset: asynchronous, empty list, registers at their defaults.
module spectrum_top_peak_picker_core
	import spp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [47:0]          s_axis_tdata,  // bin_power[23:0], bin_amplitude[47:24]
	input  logic                 s_axis_tlast,  // final_bin
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [111:0]         m_axis_tdata,  // peak_bin, peak_frequency, peak_amplitude,
	                                            // peak_ratio (lowest first)
	output logic                 m_axis_tuser,  // peak_found
	output logic                 m_axis_tlast,  // last_peak
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [FREQ_W-1:0]    cfg_data
);

	localparam logic [2:0] ST_RUN  = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_TAKE = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]            state_q;
	logic [FREQ_W-1:0]     min_freq_q;
	logic [STEP_W-1:0]     step_exp_q;

	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [POWER_BITS-1:0] prev_pow_q;
	logic [POWER_BITS-1:0] prev2_pow_q;
	logic [AMP_W-1:0]      prev_amp_q;

	logic [PN_W-1:0]       pn_q;
	logic                  pend_q;
	logic                  out_valid_q;
	logic                  out_last_q;
	logic                  found_q;
	logic [BIN_W-1:0]      res_bin_q;
	logic [FREQ_W-1:0]     res_freq_q;
	logic [AMP_W-1:0]      res_amp_q;
	logic [RATIO_W-1:0]    res_ratio_q;

	logic                  in_acc;
	logic                  room;
	logic                  is_peak;
	logic [POWER_BITS-1:0] bin_pow;
	logic [AMP_W-1:0]      bin_amp;
	logic                  qual;
	logic                  out_acc;
	logic                  div_start;
	logic                  div_done;
	logic [RATIO_W-1:0]    div_ratio;
	logic [BIN_W+FRAC_W-1:0] freq_off;

	cell_ctl_t             ctl;
	peak_entry_t           new_ent;
	peak_entry_t           ent_w [TOP_PEAKS];
	logic                  gt_w  [TOP_PEAKS];
	peak_entry_t           head;

	assign bin_pow = s_axis_tdata[POWER_BITS-1:0];
	assign bin_amp = s_axis_tdata[POWER_BITS +: AMP_W];

	assign s_axis_tready = (state_q == ST_RUN);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign room          = cnt_q < CNT_W'(MAX_BINS);
	assign is_peak       = (cnt_q[CNT_W-1:1] != '0) && (prev_pow_q > prev2_pow_q)
	                       && (prev_pow_q > bin_pow);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_ratio_q, res_amp_q, res_freq_q, res_bin_q};
	assign m_axis_tuser  = found_q;
	assign m_axis_tlast  = out_last_q;
	assign out_acc       = out_valid_q && m_axis_tready;

	assign head     = ent_w[0];
	assign qual     = head.valid && (pn_q > {sum_q, 1'b0});
	assign freq_off = {head.idx, {FRAC_W{1'b0}}} >> step_exp_q;

	// Chain commands
	assign new_ent    = '{valid: 1'b1, power: prev_pow_q, amp: prev_amp_q,
	                      idx: BIN_W'(cnt_q - 1'b1)};
	assign ctl.insert = in_acc && room && is_peak;
	assign ctl.pop    = (state_q == ST_TAKE);
	assign ctl.clear  = (state_q == ST_OUT) && out_acc && out_last_q;
	assign div_start  = (state_q == ST_TAKE);

	// Peak list chain, strongest at cell 0
	for (genvar i = 0; i < TOP_PEAKS; i++) begin : g_cell
		peak_entry_t up_e;
		peak_entry_t down_e;
		logic        up_g;
		if (i == 0) begin : g_first
			assign up_e = '0;
			assign up_g = 1'b0;
		end else begin : g_mid
			assign up_e = ent_w[i-1];
			assign up_g = gt_w[i-1];
		end
		if (i == TOP_PEAKS - 1) begin : g_last
			assign down_e = '0;
		end else begin : g_inner
			assign down_e = ent_w[i+1];
		end
		spp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.new_ent  (new_ent),
			.up_ent   (up_e),
			.up_gt    (up_g),
			.down_ent (down_e),
			.ent      (ent_w[i]),
			.gt       (gt_w[i])
		);
	end

	spp_ratio_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.pn     (pn_q),
		.sum    (sum_q),
		.done   (div_done),
		.ratio  (div_ratio)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_freq_q <= FREQ_W'(64'd16777216);
			step_exp_q <= STEP_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_FREQ: min_freq_q <= cfg_data;
				REG_STEP_EXP: step_exp_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Run state: power sum, bin count, neighbor history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			prev_pow_q  <= '0;
			prev2_pow_q <= '0;
			prev_amp_q  <= '0;
		end else if (ctl.clear) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			prev_pow_q  <= '0;
			prev2_pow_q <= '0;
			prev_amp_q  <= '0;
		end else if (in_acc && room) begin
			sum_q       <= sum_q + SUM_W'(bin_pow);
			cnt_q       <= cnt_q + 1'b1;
			prev2_pow_q <= prev_pow_q;
			prev_pow_q  <= bin_pow;
			prev_amp_q  <= bin_amp;
		end
	end

	// Result sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (in_acc && s_axis_tlast) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (pend_q) begin
						out_last_q  <= !qual;
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end else if (qual) begin
						state_q <= ST_TAKE;
					end else begin
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_TAKE: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						pend_q  <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						pend_q      <= 1'b0;
						state_q     <= out_last_q ? ST_RUN : ST_TAKE;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: pn_q <= PN_W'(head.power) * PN_W'(cnt_q);
			ST_CMP: begin
				if (!pend_q && !qual) begin
					found_q     <= 1'b0;
					res_bin_q   <= '0;
					res_freq_q  <= '0;
					res_amp_q   <= '0;
					res_ratio_q <= '0;
				end
			end
			ST_TAKE: begin
				found_q    <= 1'b1;
				res_bin_q  <= head.idx;
				res_amp_q  <= head.amp;
				res_freq_q <= min_freq_q + FREQ_W'(freq_off);
			end
			ST_DIV: begin
				if (div_done) begin
					res_ratio_q <= div_ratio;
				end
			end
			default: ;
		endcase
	end

endmodule
